>>> hdl/asidgen_pkg.sv
// Shared types and constants for the ASID generation slot allocator.
package asidgen_pkg;

  // Default table geometry.
  localparam int NUM_SLOTS_DEF = 64;
  localparam int GEN_BITS_DEF  = 32;

  // Command codes carried on the cmd field.
  typedef enum logic [2:0] {
    CMD_ACQUIRE  = 3'd0,
    CMD_RESOLVE  = 3'd1,
    CMD_CHECK    = 3'd2,
    CMD_BEGIN    = 3'd3,
    CMD_COMPLETE = 3'd4
  } cmd_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_STALE        = 3'd1,
    ST_NOT_ACTIVE   = 3'd2,
    ST_NOT_RETIRING = 3'd3,
    ST_EXHAUSTED    = 3'd4,
    ST_GEN_EXHAUST  = 3'd5
  } status_t;

  // Lifecycle state of one slot.
  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_ACTIVE   = 2'd1,
    SLOT_RETIRING = 2'd2
  } slot_state_t;

  // Sequencer state of the top level.
  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_EXEC = 1'b1
  } ctl_state_t;

endpackage

>>> hdl/asid_generation_slot_allocator.sv
// Top level of the ASID slot allocator with per-slot generation counters.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_ready  | cmd, slot_index, handle_generation, handle_asid
//  output   | out_valid / out_ready| status, out_slot, out_generation, out_asid,
//           |                      | is_active, is_retiring, active_total,
//           |                      | retiring_total
//
// The transfer issues the slot table read (at the lowest free slot for acquire);
// the evaluate step, once the output register is free, evaluates the command,
// writes the table back and loads the output register. A new transfer is taken
// only after the evaluate step of the last. A waiting result does not block the
// next input transfer, only the evaluate step.
// Reset is synchronous; every slot reads as free with generation zero at once.
module asid_generation_slot_allocator #(
  parameter int NUM_SLOTS = asidgen_pkg::NUM_SLOTS_DEF,
  parameter int GEN_BITS  = asidgen_pkg::GEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  slot_index,
  input  logic [31:0] handle_generation,
  input  logic [8:0]  handle_asid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  out_slot,
  output logic [31:0] out_generation,
  output logic [8:0]  out_asid,
  output logic        is_active,
  output logic        is_retiring,
  output logic [7:0]  active_total,
  output logic [7:0]  retiring_total
);
  import asidgen_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W = (GEN_BITS > 32) ? GEN_BITS : 32;

  ctl_state_t ctl_state, ctl_state_next;

  // Command captured at the input transfer.
  cmd_t                 cmd_q;
  logic [7:0]           slot_q;
  logic [31:0]          hgen_q;
  logic [8:0]           hasid_q;
  logic                 found_q;
  logic [IDX_W-1:0]     free_idx_q;

  logic [NUM_SLOTS-1:0] free_map;
  logic [CNT_W-1:0]     active_slots;
  logic [CNT_W-1:0]     retiring_slots;

  logic                 in_fire;
  logic                 exec_fire;
  logic                 found;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     rd_addr;
  slot_state_t          rd_state;
  logic [GEN_BITS-1:0]  rd_gen;

  // Evaluate-step results.
  logic                 wr_en;
  logic                 gen_wr_en;
  logic [IDX_W-1:0]     wr_addr;
  slot_state_t          wr_state;
  logic [GEN_BITS-1:0]  gen_inc;
  status_t              res_status;
  logic [7:0]           res_slot;
  logic [31:0]          res_gen;
  logic [8:0]           res_asid;
  logic                 res_act;
  logic                 res_ret;
  logic                 in_range;
  logic                 gen_match;
  logic                 asid_ok;
  logic                 inc_active;
  logic                 dec_active;
  logic                 inc_retiring;
  logic                 dec_retiring;

  assign in_ready  = (ctl_state == CTL_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign exec_fire = (ctl_state == CTL_EXEC) && (!out_valid || out_ready);

  asidgen_find_free #(
    .NUM_SLOTS(NUM_SLOTS),
    .IDX_W    (IDX_W)
  ) u_find_free (
    .free_map(free_map),
    .found   (found),
    .idx     (free_idx)
  );

  // Acquire reads the lowest free slot, every other command the named one.
  assign rd_addr = (cmd == CMD_ACQUIRE) ? free_idx : slot_index[IDX_W-1:0];

  asidgen_slot_mem #(
    .NUM_SLOTS(NUM_SLOTS),
    .GEN_BITS (GEN_BITS),
    .IDX_W    (IDX_W)
  ) u_slot_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_fire),
    .rd_addr  (rd_addr),
    .rd_state (rd_state),
    .rd_gen   (rd_gen),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_state (wr_state),
    .gen_wr_en(gen_wr_en),
    .wr_gen   (gen_inc)
  );

  // Sequencer register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_state <= CTL_IDLE;
    end else begin
      ctl_state <= ctl_state_next;
    end
  end

  // Sequencer next state: read step, then evaluate once the output drains.
  always_comb begin
    ctl_state_next = ctl_state;
    unique case (ctl_state)
      CTL_IDLE: if (in_fire) ctl_state_next = CTL_EXEC;
      CTL_EXEC: if (exec_fire) ctl_state_next = CTL_IDLE;
      default:  ctl_state_next = CTL_IDLE;
    endcase
  end

  // Capture the command at the input transfer.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q      <= cmd_t'(cmd);
      slot_q     <= slot_index;
      hgen_q     <= handle_generation;
      hasid_q    <= handle_asid;
      found_q    <= found;
      free_idx_q <= free_idx;
    end
  end

  // Handle validation against the slot read back from the table.
  assign in_range  = slot_q < 8'(NUM_SLOTS);
  assign gen_match = (hgen_q != '0) && in_range && (CMP_W'(rd_gen) == CMP_W'(hgen_q));
  assign asid_ok   = (hasid_q == (9'(slot_q) + 9'd1));
  assign gen_inc   = rd_gen + GEN_BITS'(1);

  // Command evaluation and table write-back.
  always_comb begin
    wr_en        = 1'b0;
    gen_wr_en    = 1'b0;
    wr_addr      = slot_q[IDX_W-1:0];
    wr_state     = SLOT_FREE;
    res_status   = ST_STALE;
    res_slot     = '0;
    res_gen      = '0;
    res_asid     = '0;
    res_act      = 1'b0;
    res_ret      = 1'b0;
    inc_active   = 1'b0;
    dec_active   = 1'b0;
    inc_retiring = 1'b0;
    dec_retiring = 1'b0;
    unique case (cmd_q)
      CMD_ACQUIRE: begin
        wr_addr = free_idx_q;
        if (!found_q) begin
          res_status = ST_EXHAUSTED;
        end else if (&rd_gen) begin
          res_status = ST_GEN_EXHAUST;
        end else begin
          wr_en      = exec_fire;
          gen_wr_en  = exec_fire;
          wr_state   = SLOT_ACTIVE;
          inc_active = 1'b1;
          res_status = ST_OK;
          res_slot   = 8'(free_idx_q);
          res_gen    = 32'(gen_inc);
          res_asid   = 9'(free_idx_q) + 9'd1;
        end
      end
      CMD_RESOLVE: begin
        if (gen_match && rd_state == SLOT_ACTIVE) begin
          res_status = ST_OK;
          res_slot   = slot_q;
          res_gen    = 32'(rd_gen);
          res_asid   = 9'(slot_q) + 9'd1;
        end
      end
      CMD_CHECK: begin
        res_status = ST_OK;
        res_act    = gen_match && asid_ok && rd_state == SLOT_ACTIVE;
        res_ret    = gen_match && asid_ok && rd_state == SLOT_RETIRING;
      end
      CMD_BEGIN: begin
        if (!gen_match || !asid_ok) begin
          res_status = ST_STALE;
        end else if (rd_state != SLOT_ACTIVE) begin
          res_status = ST_NOT_ACTIVE;
        end else begin
          wr_en        = exec_fire;
          wr_state     = SLOT_RETIRING;
          dec_active   = 1'b1;
          inc_retiring = 1'b1;
          res_status   = ST_OK;
          res_slot     = slot_q;
          res_gen      = hgen_q;
          res_asid     = hasid_q;
        end
      end
      CMD_COMPLETE: begin
        if (gen_match && asid_ok && rd_state == SLOT_RETIRING) begin
          wr_en        = exec_fire;
          wr_state     = SLOT_FREE;
          dec_retiring = 1'b1;
          res_status   = ST_OK;
        end else begin
          res_status = ST_NOT_RETIRING;
        end
      end
      default: res_status = ST_STALE;
    endcase
  end

  // Free bitmap and lifecycle counts, updated as the evaluate step commits.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_map       <= '1;
      active_slots   <= '0;
      retiring_slots <= '0;
    end else if (exec_fire) begin
      if (wr_en) begin
        free_map[wr_addr] <= (wr_state == SLOT_FREE);
      end
      if (inc_active) begin
        active_slots <= active_slots + CNT_W'(1);
      end else if (dec_active) begin
        active_slots <= active_slots - CNT_W'(1);
      end
      if (inc_retiring) begin
        retiring_slots <= retiring_slots + CNT_W'(1);
      end else if (dec_retiring) begin
        retiring_slots <= retiring_slots - CNT_W'(1);
      end
    end
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload; the counts shown are those after the command.
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      status         <= res_status;
      out_slot       <= res_slot;
      out_generation <= res_gen;
      out_asid       <= res_asid;
      is_active      <= res_act;
      is_retiring    <= res_ret;
      active_total   <= 8'(inc_active ? active_slots + CNT_W'(1) :
                           dec_active ? active_slots - CNT_W'(1) : active_slots);
      retiring_total <= 8'(inc_retiring ? retiring_slots + CNT_W'(1) :
                           dec_retiring ? retiring_slots - CNT_W'(1) : retiring_slots);
    end
  end

`ifndef SYNTHESIS
  // Active and retiring slots never outnumber the table.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (9'(active_slots) + 9'(retiring_slots)) <= 9'(NUM_SLOTS))
    else $error("slot counts exceed table size");

  // An acquire that finds a free slot only ever grants a slot marked free.
  a_free_grant: assert property (@(posedge clk) disable iff (rst)
    (ctl_state == CTL_EXEC && cmd_q == CMD_ACQUIRE && found_q) |-> free_map[free_idx_q])
    else $error("acquire selected a slot that is not free");

  // A granted or resolved result always carries ASID equal to slot plus one.
  a_asid_slot: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && res_status == ST_OK && (cmd_q == CMD_ACQUIRE || cmd_q == CMD_RESOLVE))
    |=> (out_asid == 9'(out_slot) + 9'd1))
    else $error("ASID does not match slot");

  // The table is never written back except in the evaluate step.
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (ctl_state == CTL_EXEC && exec_fire))
    else $error("slot table written outside the evaluate step");
`endif

endmodule

>>> hdl/asidgen_slot_mem.sv
// Slot table: lifecycle state and generation memories with registered read.
module asidgen_slot_mem #(
  parameter int NUM_SLOTS = asidgen_pkg::NUM_SLOTS_DEF,
  parameter int GEN_BITS  = asidgen_pkg::GEN_BITS_DEF,
  parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [IDX_W-1:0]          rd_addr,
  output asidgen_pkg::slot_state_t  rd_state,
  output logic [GEN_BITS-1:0]       rd_gen,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_addr,
  input  asidgen_pkg::slot_state_t  wr_state,
  input  logic                      gen_wr_en,
  input  logic [GEN_BITS-1:0]       wr_gen
);
  import asidgen_pkg::*;

  slot_state_t          state_mem [NUM_SLOTS];
  logic [GEN_BITS-1:0]  gen_mem   [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] written;

  // A slot is first written by an acquire, which writes both memories, so one
  // written bit per slot covers both. Unwritten slots read as free, generation zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (gen_wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      state_mem[wr_addr] <= wr_state;
    end
    if (gen_wr_en) begin
      gen_mem[wr_addr] <= wr_gen;
    end
  end

  // Read port, registered; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_state <= written[rd_addr] ? state_mem[rd_addr] : SLOT_FREE;
      rd_gen   <= written[rd_addr] ? gen_mem[rd_addr] : '0;
    end
  end

endmodule

>>> hdl/asidgen_find_free.sv
// Lowest-index search over the free-slot bitmap.
module asidgen_find_free #(
  parameter int NUM_SLOTS = asidgen_pkg::NUM_SLOTS_DEF,
  parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic [NUM_SLOTS-1:0] free_map,
  output logic                 found,
  output logic [IDX_W-1:0]     idx
);

  // Scan from the top so that the lowest free slot wins.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

endmodule

>>> test/tb_asid_generation_slot_allocator.sv
// Self-checking testbench for the ASID generation slot allocator.
`timescale 1ns / 1ps

module tb_asid_generation_slot_allocator;
  import asidgen_pkg::*;

  localparam int          CYCLE_LIMIT   = 100000;
  localparam int          RANDOM_ITEMS  = 750;
  localparam int          TAIL_ITEMS    = 120;
  localparam int          DRAIN_CYCLES  = 20;
  localparam int          MAX_REPORTS   = 10;
  localparam logic [31:0] GEN_CEILING   = '1;
  localparam logic [2:0]  CMD_UNKNOWN_LO = 3'd5;
  localparam logic [2:0]  CMD_UNKNOWN_HI = 3'd7;

  // One result transfer of the block.
  typedef struct {
    status_t     status;
    logic [7:0]  slot;
    logic [31:0] gen;
    logic [8:0]  asid;
    logic        act;
    logic        ret;
    logic [7:0]  act_tot;
    logic [7:0]  ret_tot;
  } alloc_result_t;

  // Mirror of the slot table plus the queue of results it predicts.
  class asid_table_tracker;
    slot_state_t   slot_state [NUM_SLOTS_DEF];
    logic [31:0]   slot_gen [NUM_SLOTS_DEF];
    int            live_slots;
    int            draining_slots;
    alloc_result_t expected_results [$];
    int            errors;
    int            checked;
    int            status_seen [8];

    function new();
      int i;
      for (i = 0; i < NUM_SLOTS_DEF; i++) begin
        slot_state[i] = SLOT_FREE;
        slot_gen[i]   = '0;
      end
      for (i = 0; i < 8; i++) status_seen[i] = 0;
      live_slots     = 0;
      draining_slots = 0;
      errors         = 0;
      checked        = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // A random slot in the wanted state, or -1 if there is none.
    function int pick_slot(slot_state_t want);
      int start;
      int k;
      int idx;
      start = $urandom_range(NUM_SLOTS_DEF - 1, 0);
      for (k = 0; k < NUM_SLOTS_DEF; k++) begin
        idx = (start + k) % NUM_SLOTS_DEF;
        if (slot_state[idx] == want) return idx;
      end
      return -1;
    endfunction

    // A handle matches when it is in range, nonzero and of the current generation.
    function bit handle_matches(logic [7:0] slot, logic [31:0] gen);
      if (gen == '0 || slot >= NUM_SLOTS_DEF) return 1'b0;
      return slot_gen[slot] == gen;
    endfunction

    // Apply one accepted command to the table and queue its result.
    function void record_command(logic [2:0] op, logic [7:0] slot, logic [31:0] gen,
                                 logic [8:0] asid);
      alloc_result_t r;
      int            i;
      bit            matched;
      bit            asid_ok;
      r.status = ST_STALE;
      r.slot   = '0;
      r.gen    = '0;
      r.asid   = '0;
      r.act    = 1'b0;
      r.ret    = 1'b0;
      matched  = handle_matches(slot, gen);
      asid_ok  = (asid == {1'b0, slot} + 9'd1);
      case (op)
        CMD_ACQUIRE: begin
          // Only the lowest free slot is ever considered.
          r.status = ST_EXHAUSTED;
          for (i = 0; i < NUM_SLOTS_DEF; i++) begin
            if (slot_state[i] == SLOT_FREE) begin
              if (slot_gen[i] == GEN_CEILING) begin
                r.status = ST_GEN_EXHAUST;
              end else begin
                slot_gen[i]   = slot_gen[i] + 32'd1;
                slot_state[i] = SLOT_ACTIVE;
                live_slots++;
                r.status = ST_OK;
                r.slot   = 8'(i);
                r.gen    = slot_gen[i];
                r.asid   = 9'(i + 1);
              end
              break;
            end
          end
        end
        CMD_RESOLVE: begin
          if (matched && slot_state[slot] == SLOT_ACTIVE) begin
            r.status = ST_OK;
            r.slot   = slot;
            r.gen    = slot_gen[slot];
            r.asid   = {1'b0, slot} + 9'd1;
          end
        end
        CMD_CHECK: begin
          r.status = ST_OK;
          r.act    = matched && asid_ok && slot_state[slot] == SLOT_ACTIVE;
          r.ret    = matched && asid_ok && slot_state[slot] == SLOT_RETIRING;
        end
        CMD_BEGIN: begin
          if (!matched || !asid_ok) begin
            r.status = ST_STALE;
          end else if (slot_state[slot] != SLOT_ACTIVE) begin
            r.status = ST_NOT_ACTIVE;
          end else begin
            slot_state[slot] = SLOT_RETIRING;
            live_slots--;
            draining_slots++;
            r.status = ST_OK;
            r.slot   = slot;
            r.gen    = gen;
            r.asid   = asid;
          end
        end
        CMD_COMPLETE: begin
          if (matched && asid_ok && slot_state[slot] == SLOT_RETIRING) begin
            slot_state[slot] = SLOT_FREE;
            draining_slots--;
            r.status = ST_OK;
          end else begin
            r.status = ST_NOT_RETIRING;
          end
        end
        default: r.status = ST_STALE;
      endcase
      r.act_tot = 8'(live_slots);
      r.ret_tot = 8'(draining_slots);
      expected_results.push_back(r);
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_response(alloc_result_t got);
      alloc_result_t want;
      checked++;
      status_seen[got.status]++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("Unexpected result: status %0d slot %0d", got.status, got.slot);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.slot !== want.slot || got.gen !== want.gen ||
          got.asid !== want.asid || got.act !== want.act || got.ret !== want.ret ||
          got.act_tot !== want.act_tot || got.ret_tot !== want.ret_tot) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("Mismatch on result %0d: expected st=%0d slot=%0d gen=%h asid=%0d",
                   checked, want.status, want.slot, want.gen, want.asid);
          $display("  act=%0b ret=%0b totals=%0d/%0d; got st=%0d slot=%0d gen=%h asid=%0d",
                   want.act, want.ret, want.act_tot, want.ret_tot,
                   got.status, got.slot, got.gen, got.asid);
          $display("  act=%0b ret=%0b totals=%0d/%0d",
                   got.act, got.ret, got.act_tot, got.ret_tot);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  cmd = CMD_ACQUIRE;
  logic [7:0]  slot_index = '0;
  logic [31:0] handle_generation = '0;
  logic [8:0]  handle_asid = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [7:0]  out_slot;
  logic [31:0] out_generation;
  logic [8:0]  out_asid;
  logic        is_active;
  logic        is_retiring;
  logic [7:0]  active_total;
  logic [7:0]  retiring_total;

  asid_table_tracker tracker = new();
  alloc_result_t     seen_result;
  int                cycle_count = 0;
  int                sent_count = 0;
  int                idle_pct = 15;
  int                stall_left = 0;
  bit                quiet_tail = 1'b0;
  bit                filling = 1'b1;

  asid_generation_slot_allocator u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .cmd               (cmd),
    .slot_index        (slot_index),
    .handle_generation (handle_generation),
    .handle_asid       (handle_asid),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .out_slot          (out_slot),
    .out_generation    (out_generation),
    .out_asid          (out_asid),
    .is_active         (is_active),
    .is_retiring       (is_retiring),
    .active_total      (active_total),
    .retiring_total    (retiring_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver stalls in short random bursts, except in the tail of the run.
  always @(posedge clk) begin
    if (quiet_tail || stall_left == 0) begin
      out_ready <= 1'b1;
      if (!quiet_tail && $urandom_range(99, 0) < idle_pct)
        stall_left <= $urandom_range(3, 1);
    end else begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  // Signals settle between edges, so the falling edge sees what the next rising edge takes.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        tracker.record_command(cmd, slot_index, handle_generation, handle_asid);
      if (out_valid && out_ready) begin
        seen_result.status  = status_t'(status);
        seen_result.slot    = out_slot;
        seen_result.gen     = out_generation;
        seen_result.asid    = out_asid;
        seen_result.act     = is_active;
        seen_result.ret     = is_retiring;
        seen_result.act_tot = active_total;
        seen_result.ret_tot = retiring_total;
        tracker.check_response(seen_result);
      end
    end
  end

  // Present one command and hold it until the transfer edge has passed.
  task automatic issue_command(input logic [2:0] op, input logic [7:0] slot,
                               input logic [31:0] gen, input logic [8:0] asid);
    in_valid          <= 1'b1;
    cmd               <= op;
    slot_index        <= slot;
    handle_generation <= gen;
    handle_asid       <= asid;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sent_count++;
  endtask

  task automatic sender_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(3, 1)) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Mostly lifecycle traffic on live handles, with some corrupted handles and noise.
  task automatic issue_random_command();
    int          pick;
    int          s;
    int          occupancy;
    logic [2:0]  op;
    logic [7:0]  slot;
    logic [31:0] gen;
    logic [8:0]  asid;
    occupancy = tracker.live_slots + tracker.draining_slots;
    if (filling && occupancy >= NUM_SLOTS_DEF && $urandom_range(3, 0) == 0)
      filling = 1'b0;
    else if (!filling && occupancy <= 2)
      filling = 1'b1;
    op   = CMD_ACQUIRE;
    slot = 8'($urandom);
    gen  = $urandom;
    asid = 9'($urandom);
    pick = $urandom_range(99, 0);
    if (pick < (filling ? 55 : 10)) begin
      op = CMD_ACQUIRE;
    end else if (pick < (filling ? 62 : 18)) begin
      op = 3'($urandom_range(7, 0));
    end else begin
      pick = $urandom_range(99, 0);
      if (pick < 15) begin
        op = CMD_RESOLVE;
        s  = tracker.pick_slot(SLOT_ACTIVE);
      end else if (pick < 30) begin
        op = CMD_CHECK;
        s  = $urandom_range(NUM_SLOTS_DEF - 1, 0);
      end else if (pick < 65) begin
        op = CMD_BEGIN;
        s  = tracker.pick_slot(SLOT_ACTIVE);
      end else begin
        op = CMD_COMPLETE;
        s  = tracker.pick_slot(SLOT_RETIRING);
      end
      if (s < 0) s = $urandom_range(NUM_SLOTS_DEF - 1, 0);
      slot = 8'(s);
      gen  = tracker.slot_gen[s];
      if (op != CMD_RESOLVE || $urandom_range(1, 0) == 1) asid = {1'b0, slot} + 9'd1;
      // Damage one part of the handle now and then.
      if ($urandom_range(99, 0) < 15) begin
        case ($urandom_range(4, 0))
          0:       gen  = gen + 32'd1;
          1:       gen  = gen - 32'd1;
          2:       asid = asid ^ 9'(1 << $urandom_range(8, 0));
          3:       slot = 8'($urandom_range(255, NUM_SLOTS_DEF));
          default: gen  = '0;
        endcase
      end
    end
    issue_command(op, slot, gen, asid);
  endtask

  initial begin
    int u;
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Invalid handles against an empty table.
    issue_command(CMD_CHECK, 8'd0, 32'd0, 9'd1);
    issue_command(CMD_RESOLVE, 8'd0, 32'd0, 9'd1);
    issue_command(CMD_COMPLETE, 8'd0, 32'd0, 9'd1);
    issue_command(CMD_BEGIN, 8'd0, 32'd0, 9'd1);
    // Two grants, then one full lifecycle of slot zero with wrong handles mixed in.
    issue_command(CMD_ACQUIRE, 8'd0, 32'd0, 9'd0);
    issue_command(CMD_ACQUIRE, 8'hFF, '1, 9'h1FF);
    issue_command(CMD_RESOLVE, 8'd0, 32'd1, 9'd0);
    issue_command(CMD_CHECK, 8'd0, 32'd1, 9'd1);
    issue_command(CMD_CHECK, 8'd0, 32'd1, 9'd2);
    issue_command(CMD_BEGIN, 8'd0, 32'd1, 9'd2);
    issue_command(CMD_BEGIN, 8'd0, 32'd1, 9'd1);
    issue_command(CMD_BEGIN, 8'd0, 32'd1, 9'd1);
    issue_command(CMD_CHECK, 8'd0, 32'd1, 9'd1);
    issue_command(CMD_RESOLVE, 8'd0, 32'd1, 9'd1);
    issue_command(CMD_COMPLETE, 8'd0, 32'd2, 9'd1);
    issue_command(CMD_COMPLETE, 8'd0, 32'd1, 9'd1);
    // Regrant bumps the generation, so the old handle goes stale.
    issue_command(CMD_ACQUIRE, 8'd0, 32'd0, 9'd0);
    issue_command(CMD_RESOLVE, 8'd0, 32'd1, 9'd1);
    issue_command(CMD_RESOLVE, 8'hFF, '1, 9'h1FF);
    issue_command(CMD_CHECK, 8'(NUM_SLOTS_DEF), 32'd1, 9'(NUM_SLOTS_DEF + 1));
    for (u = CMD_UNKNOWN_LO; u <= CMD_UNKNOWN_HI; u++)
      issue_command(3'(u), 8'hFF, '1, 9'h1FF);
    issue_command(CMD_COMPLETE, 8'd1, 32'd1, 9'd2);
    hold_until_drained();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(2, 0))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 35;
        endcase
      end
      if (n == RANDOM_ITEMS - TAIL_ITEMS) begin
        quiet_tail = 1'b1;
        idle_pct   = 0;
      end
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      issue_random_command();
      if (!quiet_tail && $urandom_range(99, 0) < idle_pct) sender_gap();
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d commands, %0d results: ok %0d, stale %0d, not active %0d.",
             sent_count, tracker.checked, tracker.status_seen[ST_OK],
             tracker.status_seen[ST_STALE], tracker.status_seen[ST_NOT_ACTIVE]);
    $display("Not retiring %0d, table full %0d, generation ceiling %0d, mismatches %0d.",
             tracker.status_seen[ST_NOT_RETIRING], tracker.status_seen[ST_EXHAUSTED],
             tracker.status_seen[ST_GEN_EXHAUST], tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
